/* sv/cdmu_pkg.sv */
`default_nettype none

package cdmu_pkg;

   // Kind of memory access requested by a result
   typedef enum logic [1:0] {
      ACC_READ  = 2'd0,
      ACC_WRITE = 2'd1,
      ACC_NONE  = 2'd2
   } access_kind_type;

   // Completion status
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_HALT_REJ  = 2'd1,
      ST_UNHANDLED = 2'd2,
      ST_STRAY_RD  = 2'd3
   } status_type;

   // What the unit is waiting for
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ONE_RD = 2'd1,
      PH_LXI_LO = 2'd2,
      PH_LXI_HI = 2'd3
   } phase_type;

   // Request kinds
   localparam logic REQ_OPCODE = 1'b0;
   localparam logic REQ_RDATA  = 1'b1;

   // Opcode patterns
   localparam logic [7:0] OP_HLT      = 8'b0111_0110;
   localparam logic [7:0] MASK_MOV    = 8'b1100_0000;
   localparam logic [7:0] PAT_MOV     = 8'b0100_0000;
   localparam logic [7:0] MASK_LDST   = 8'b1110_0111;
   localparam logic [7:0] PAT_LDST    = 8'b0000_0010;
   localparam logic [7:0] MASK_MVI    = 8'b1100_0111;
   localparam logic [7:0] PAT_MVI     = 8'b0000_0110;
   localparam logic [7:0] MASK_LXI    = 8'b1100_1111;
   localparam logic [7:0] PAT_LXI     = 8'b0000_0001;

   // Register codes
   localparam logic [2:0] RC_MEM = 3'd6;
   localparam logic [2:0] RC_A   = 3'd7;
   localparam logic [1:0] RP_SP  = 2'd3;

   // Register file slots
   localparam logic [2:0] SLOT_H = 3'd4;
   localparam logic [2:0] SLOT_L = 3'd5;
   localparam logic [2:0] SLOT_A = 3'd6;
   localparam int         NUM_REGS = 7;

   // Cycle counts
   localparam logic [3:0] CYC_NONE  = 4'd0;
   localparam logic [3:0] CYC_HLT   = 4'd4;
   localparam logic [3:0] CYC_MOVRR = 4'd5;
   localparam logic [3:0] CYC_SHORT = 4'd7;
   localparam logic [3:0] CYC_LONG  = 4'd10;

endpackage

`default_nettype wire

/* sv/cpu8080_data_move_unit.sv */
`default_nettype none

// A request passes two register stages (input register, result register).
// One request per cycle while rsp_stall does not hold the result register;
// the register file updates in the decode cycle.
// Reset (synchronous, active high) clears both valid flags, registers B..A, SP, PC,
// the pending opcode, the low byte and returns the unit to idle.
module cpu8080_data_move_unit
   import cdmu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_opcode,
   input  wire logic [7:0]  req_read_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_access_kind,
   output logic [15:0]      rsp_mem_addr,
   output logic [7:0]       rsp_mem_wdata,
   output logic             rsp_done_res,
   output logic [3:0]       rsp_cycle_count,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_dest_value
);

   // Register code to file slot (A lives at slot 6)
   function automatic logic [2:0] reg_slot(input logic [2:0] code);
      logic [2:0] slot;
      if (code == RC_A) begin
         slot = SLOT_A;
      end else if (code > SLOT_L) begin
         slot = SLOT_L;
      end else begin
         slot = code;
      end
      return slot;
   endfunction

   // Input register
   logic       in_vld_ff, in_vld_in;
   logic       in_type_ff;
   logic [7:0] in_op_ff, in_data_ff;
   logic       advance, accept;

   // Result register
   logic            out_vld_ff, out_vld_in;
   access_kind_type out_kind_ff, out_kind_in;
   logic [15:0]     out_addr_ff, out_addr_in;
   logic [7:0]      out_wdata_ff, out_wdata_in;
   logic            out_done_ff, out_done_in;
   logic [3:0]      out_cyc_ff, out_cyc_in;
   status_type      out_status_ff, out_status_in;
   logic [15:0]     out_dest_ff, out_dest_in;

   // Architectural state
   logic [7:0]  regs_ff [NUM_REGS];
   logic [7:0]  regs_in [NUM_REGS];
   logic [15:0] sp_ff, sp_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  pend_ff, pend_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  low_ff, low_in;

   // Handshake
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // Decode and execute
   always_comb begin
      logic [15:0] hl;
      logic [15:0] bc_de;
      logic [2:0]  dst;
      logic [2:0]  src;
      logic [1:0]  rp;
      logic [15:0] pair_val;

      hl       = {regs_ff[SLOT_H], regs_ff[SLOT_L]};
      dst      = in_op_ff[5:3];
      src      = in_op_ff[2:0];
      bc_de    = {regs_ff[{1'b0, in_op_ff[4], 1'b0}], regs_ff[{1'b0, in_op_ff[4], 1'b1}]};
      rp       = pend_ff[5:4];
      pair_val = {in_data_ff, low_ff};

      out_kind_in   = ACC_NONE;
      out_addr_in   = '0;
      out_wdata_in  = '0;
      out_done_in   = 1'b0;
      out_cyc_in    = CYC_NONE;
      out_status_in = ST_OK;
      out_dest_in   = '0;

      regs_in  = regs_ff;
      sp_in    = sp_ff;
      pc_in    = pc_ff;
      pend_in  = pend_ff;
      phase_in = phase_ff;
      low_in   = low_ff;

      if (in_type_ff == REQ_OPCODE) begin
         phase_in = PH_IDLE;
         if (in_op_ff == OP_HLT) begin
            out_done_in   = 1'b1;
            out_cyc_in    = CYC_HLT;
            out_status_in = ST_HALT_REJ;
         end else if ((in_op_ff & MASK_MOV) == PAT_MOV) begin
            if (src == RC_MEM) begin
               // MOV r,M: fetch operand at HL
               pend_in     = in_op_ff;
               phase_in    = PH_ONE_RD;
               out_kind_in = ACC_READ;
               out_addr_in = hl;
            end else if (dst == RC_MEM) begin
               out_kind_in  = ACC_WRITE;
               out_addr_in  = hl;
               out_wdata_in = regs_ff[reg_slot(src)];
               out_done_in  = 1'b1;
               out_cyc_in   = CYC_SHORT;
            end else begin
               regs_in[reg_slot(dst)] = regs_ff[reg_slot(src)];
               out_done_in = 1'b1;
               out_cyc_in  = CYC_MOVRR;
               out_dest_in = {8'd0, regs_ff[reg_slot(src)]};
            end
         end else if ((in_op_ff & MASK_MVI) == PAT_MVI) begin
            pend_in     = in_op_ff;
            phase_in    = PH_ONE_RD;
            out_kind_in = ACC_READ;
            out_addr_in = pc_ff;
            pc_in       = 16'(pc_ff + 16'd1);
         end else if ((in_op_ff & MASK_LXI) == PAT_LXI) begin
            pend_in     = in_op_ff;
            phase_in    = PH_LXI_LO;
            out_kind_in = ACC_READ;
            out_addr_in = pc_ff;
            pc_in       = 16'(pc_ff + 16'd1);
         end else if ((in_op_ff & MASK_LDST) == PAT_LDST) begin
            out_addr_in = bc_de;
            if (in_op_ff[3]) begin
               // LDAX
               pend_in     = in_op_ff;
               phase_in    = PH_ONE_RD;
               out_kind_in = ACC_READ;
            end else begin
               // STAX
               out_kind_in  = ACC_WRITE;
               out_wdata_in = regs_ff[SLOT_A];
               out_done_in  = 1'b1;
               out_cyc_in   = CYC_SHORT;
            end
         end else begin
            out_status_in = ST_UNHANDLED;
         end
      end else begin
         unique case (phase_ff)
            PH_ONE_RD: begin
               phase_in = PH_IDLE;
               if ((pend_ff & MASK_LDST) == PAT_LDST) begin
                  regs_in[SLOT_A] = in_data_ff;
                  out_done_in = 1'b1;
                  out_cyc_in  = CYC_SHORT;
                  out_dest_in = {8'd0, in_data_ff};
               end else if (pend_ff[5:3] == RC_MEM) begin
                  // MVI M: store immediate at HL
                  out_kind_in  = ACC_WRITE;
                  out_addr_in  = hl;
                  out_wdata_in = in_data_ff;
                  out_done_in  = 1'b1;
                  out_cyc_in   = CYC_LONG;
               end else begin
                  regs_in[reg_slot(pend_ff[5:3])] = in_data_ff;
                  out_done_in = 1'b1;
                  out_cyc_in  = CYC_SHORT;
                  out_dest_in = {8'd0, in_data_ff};
               end
            end
            PH_LXI_LO: begin
               low_in      = in_data_ff;
               phase_in    = PH_LXI_HI;
               out_kind_in = ACC_READ;
               out_addr_in = pc_ff;
               pc_in       = 16'(pc_ff + 16'd1);
            end
            PH_LXI_HI: begin
               phase_in = PH_IDLE;
               if (rp == RP_SP) begin
                  sp_in = pair_val;
               end else begin
                  regs_in[{rp, 1'b0}] = in_data_ff;
                  regs_in[{rp, 1'b1}] = low_ff;
               end
               out_done_in = 1'b1;
               out_cyc_in  = CYC_LONG;
               out_dest_in = pair_val;
            end
            default: begin
               out_status_in = ST_STRAY_RD;
            end
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
         sp_ff    <= '0;
         pc_ff    <= '0;
         pend_ff  <= '0;
         phase_ff <= PH_IDLE;
         low_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            regs_ff  <= regs_in;
            sp_ff    <= sp_in;
            pc_ff    <= pc_in;
            pend_ff  <= pend_in;
            phase_ff <= phase_in;
            low_ff   <= low_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff <= req_type;
         in_op_ff   <= req_opcode;
         in_data_ff <= req_read_data;
      end
      if (advance) begin
         out_kind_ff   <= out_kind_in;
         out_addr_ff   <= out_addr_in;
         out_wdata_ff  <= out_wdata_in;
         out_done_ff   <= out_done_in;
         out_cyc_ff    <= out_cyc_in;
         out_status_ff <= out_status_in;
         out_dest_ff   <= out_dest_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_access_kind = out_kind_ff;
   assign rsp_mem_addr    = out_addr_ff;
   assign rsp_mem_wdata   = out_wdata_ff;
   assign rsp_done_res    = out_done_ff;
   assign rsp_cycle_count = out_cyc_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_dest_value  = out_dest_ff;

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
   import cdmu_pkg::*;

   // Register and pair codes that the package does not name
   localparam logic [2:0] RC_B = 3'd0;
   localparam logic [2:0] RC_C = 3'd1;
   localparam logic [2:0] RC_E = 3'd3;
   localparam logic [2:0] RC_H = 3'd4;
   localparam logic [2:0] RC_L = 3'd5;
   localparam logic [1:0] RP_BC = 2'd0;
   localparam logic [1:0] RP_DE = 2'd1;
   localparam logic [1:0] RP_HL = 2'd2;

   // Opcodes outside the data-transfer group
   localparam logic [7:0] OP_NOP  = 8'h00;
   localparam logic [7:0] OP_RST7 = 8'hFF;

   localparam int RANDOM_ITEMS = 920;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct packed {
      access_kind_type kind;
      logic [15:0]     addr;
      logic [7:0]      wdata;
      logic            done;
      logic [3:0]      cycles;
      status_type      status;
      logic [15:0]     dest;
   } move_result_type;

   // Register file shadow, transfer predictor and response checker
   class move_scoreboard_type;
      logic [7:0]   regs [NUM_REGS];
      logic [15:0]  stack_ptr;
      logic [15:0]  prog_ctr;
      logic [7:0]   held_op;
      logic [7:0]   lxi_low;
      phase_type    wait_phase;
      move_result_type expected_q [$];
      int errors, reads, writes, moves, halts, unhandled, strays, pc_wraps;

      function new();
         foreach (regs[i]) regs[i] = '0;
         stack_ptr  = '0;
         prog_ctr   = '0;
         held_op    = '0;
         lxi_low    = '0;
         wait_phase = PH_IDLE;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      function int slot_of(logic [2:0] code);
         return (code == RC_A) ? int'(SLOT_A) : int'(code);
      endfunction

      function logic [15:0] pair_value(logic [1:0] rp);
         if (rp == RP_SP) return stack_ptr;
         return {regs[2 * int'(rp)], regs[2 * int'(rp) + 1]};
      endfunction

      // Operand fetch from the program counter, which wraps
      function move_result_type fetch_at_pc();
         move_result_type r;
         r = '0;
         r.kind = ACC_READ;
         r.status = ST_OK;
         r.addr = prog_ctr;
         if (prog_ctr == 16'hFFFF) pc_wraps++;
         prog_ctr = prog_ctr + 16'd1;
         return r;
      endfunction

      function move_result_type apply_transfer(logic rtype, logic [7:0] op, logic [7:0] data);
         move_result_type r;
         logic [2:0]  dst;
         logic [2:0]  src;
         logic [1:0]  rp;
         logic [15:0] word;
         r = '0;
         r.kind = ACC_NONE;
         r.status = ST_OK;
         r.cycles = CYC_NONE;
         if (rtype == REQ_OPCODE) begin
            // any new opcode drops whatever was pending
            wait_phase = PH_IDLE;
            dst = op[5:3];
            src = op[2:0];
            if (op == OP_HLT) begin
               r.done = 1'b1;
               r.cycles = CYC_HLT;
               r.status = ST_HALT_REJ;
            end else if ((op & MASK_MOV) == PAT_MOV) begin
               if (src == RC_MEM) begin
                  held_op = op;
                  wait_phase = PH_ONE_RD;
                  r.kind = ACC_READ;
                  r.addr = pair_value(RP_HL);
               end else if (dst == RC_MEM) begin
                  r.kind = ACC_WRITE;
                  r.addr = pair_value(RP_HL);
                  r.wdata = regs[slot_of(src)];
                  r.done = 1'b1;
                  r.cycles = CYC_SHORT;
               end else begin
                  regs[slot_of(dst)] = regs[slot_of(src)];
                  r.done = 1'b1;
                  r.cycles = CYC_MOVRR;
                  r.dest = {8'h00, regs[slot_of(dst)]};
               end
            end else if ((op & MASK_MVI) == PAT_MVI) begin
               held_op = op;
               wait_phase = PH_ONE_RD;
               r = fetch_at_pc();
            end else if ((op & MASK_LXI) == PAT_LXI) begin
               held_op = op;
               wait_phase = PH_LXI_LO;
               r = fetch_at_pc();
            end else if ((op & MASK_LDST) == PAT_LDST) begin
               // LDAX reads through BC/DE, STAX writes A there
               r.addr = pair_value({1'b0, op[4]});
               if (op[3]) begin
                  held_op = op;
                  wait_phase = PH_ONE_RD;
                  r.kind = ACC_READ;
               end else begin
                  r.kind = ACC_WRITE;
                  r.wdata = regs[SLOT_A];
                  r.done = 1'b1;
                  r.cycles = CYC_SHORT;
               end
            end else begin
               r.status = ST_UNHANDLED;
            end
         end else begin
            case (wait_phase)
               PH_ONE_RD: begin
                  wait_phase = PH_IDLE;
                  dst = ((held_op & MASK_LDST) == PAT_LDST) ? RC_A : held_op[5:3];
                  if (dst == RC_MEM) begin
                     r.kind = ACC_WRITE;
                     r.addr = pair_value(RP_HL);
                     r.wdata = data;
                     r.done = 1'b1;
                     r.cycles = CYC_LONG;
                  end else begin
                     regs[slot_of(dst)] = data;
                     r.done = 1'b1;
                     r.cycles = CYC_SHORT;
                     r.dest = {8'h00, data};
                  end
               end
               PH_LXI_LO: begin
                  lxi_low = data;
                  wait_phase = PH_LXI_HI;
                  r = fetch_at_pc();
               end
               PH_LXI_HI: begin
                  word = {data, lxi_low};
                  rp = held_op[5:4];
                  wait_phase = PH_IDLE;
                  if (rp == RP_SP) begin
                     stack_ptr = word;
                  end else begin
                     regs[2 * int'(rp)] = word[15:8];
                     regs[2 * int'(rp) + 1] = word[7:0];
                  end
                  r.done = 1'b1;
                  r.cycles = CYC_LONG;
                  r.dest = word;
               end
               default: r.status = ST_STRAY_RD;
            endcase
         end
         return r;
      endfunction

      function void note_request(logic rtype, logic [7:0] op, logic [7:0] data);
         expected_q.push_back(apply_transfer(rtype, op, data));
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(move_result_type got);
         move_result_type want;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding (kind %0d addr %h)",
                   got.kind, got.addr);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("access_kind", want.kind, got.kind);
         compare_field("mem_addr", want.addr, got.addr);
         compare_field("mem_wdata", want.wdata, got.wdata);
         compare_field("done_res", want.done, got.done);
         compare_field("cycle_count", want.cycles, got.cycles);
         compare_field("status", want.status, got.status);
         compare_field("dest_value", want.dest, got.dest);
         // tallies for the closing summary
         if (want.kind == ACC_READ) reads++;
         if (want.kind == ACC_WRITE) writes++;
         if (want.done && want.status == ST_OK) moves++;
         if (want.status == ST_HALT_REJ) halts++;
         if (want.status == ST_UNHANDLED) unhandled++;
         if (want.status == ST_STRAY_RD) strays++;
      endfunction
   endclass

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic        req_type      = REQ_OPCODE;
   logic [7:0]  req_opcode    = '0;
   logic [7:0]  req_read_data = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [1:0]  rsp_access_kind;
   logic [15:0] rsp_mem_addr;
   logic [7:0]  rsp_mem_wdata;
   logic        rsp_done_res;
   logic [3:0]  rsp_cycle_count;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_dest_value;

   move_scoreboard_type board = new();
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;
   bit hold_off  = 1'b0;
   int items_sent = 0;
   int cycle_total = 0;

   cpu8080_data_move_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_opcode      (req_opcode),
      .req_read_data   (req_read_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_access_kind (rsp_access_kind),
      .rsp_mem_addr    (rsp_mem_addr),
      .rsp_mem_wdata   (rsp_mem_wdata),
      .rsp_done_res    (rsp_done_res),
      .rsp_cycle_count (rsp_cycle_count),
      .rsp_status      (rsp_status),
      .rsp_dest_value  (rsp_dest_value)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_total++;
      if (cycle_total > CYCLE_LIMIT) begin
         $error("no progress after %0d cycles, %0d responses outstanding",
                cycle_total, board.outstanding());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Opcode builders
   function automatic logic [7:0] mov_op(logic [2:0] dst, logic [2:0] src);
      return PAT_MOV | {2'b00, dst, src};
   endfunction

   function automatic logic [7:0] mvi_op(logic [2:0] dst);
      return PAT_MVI | {2'b00, dst, 3'b000};
   endfunction

   function automatic logic [7:0] lxi_op(logic [1:0] rp);
      return PAT_LXI | {2'b00, rp, 4'b0000};
   endfunction

   function automatic logic [7:0] ldst_op(logic use_de, logic load);
      return PAT_LDST | {3'b000, use_de, load, 3'b000};
   endfunction

   function automatic logic [7:0] random_move_op();
      case ($urandom_range(0, 3))
         0:       return mov_op(3'($urandom), 3'($urandom));
         1:       return mvi_op(3'($urandom));
         2:       return lxi_op(2'($urandom));
         default: return ldst_op(1'($urandom), 1'($urandom));
      endcase
   endfunction

   // Number of read bytes an opcode waits for
   function automatic int reads_needed(logic [7:0] op);
      if (op == OP_HLT) return 0;
      if ((op & MASK_MOV) == PAT_MOV) return (op[2:0] == RC_MEM) ? 1 : 0;
      if ((op & MASK_MVI) == PAT_MVI) return 1;
      if ((op & MASK_LXI) == PAT_LXI) return 2;
      if ((op & MASK_LDST) == PAT_LDST) return op[3] ? 1 : 0;
      return 0;
   endfunction

   // One request on the input channel; valid stays up when the next follows at once
   task automatic send_request(logic rtype, logic [7:0] op, logic [7:0] data);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= rtype;
      req_opcode    <= op;
      req_read_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      board.note_request(rtype, op, data);
   endtask

   task automatic send_opcode(logic [7:0] op);
      send_request(REQ_OPCODE, op, 8'($urandom));
   endtask

   task automatic send_byte(logic [7:0] data);
      send_request(REQ_RDATA, 8'($urandom), data);
   endtask

   // Opcode plus its read bytes; shortfall > 0 drops bytes, < 0 adds stray ones
   task automatic run_instruction(logic [7:0] op, int shortfall);
      int n;
      n = reads_needed(op) - shortfall;
      send_opcode(op);
      repeat (n) send_byte(8'($urandom));
   endtask

   // Drop valid and wait until every expected response is in
   task automatic settle();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Response side: random stalls, one long hold on request
   initial begin
      move_result_type got;
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = hold_off ? LONG_HOLD : (recv_calm ? 0 : $urandom_range(0, 15));
         hold_off = 1'b0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.kind   = access_kind_type'(rsp_access_kind);
         got.addr   = rsp_mem_addr;
         got.wdata  = rsp_mem_wdata;
         got.done   = rsp_done_res;
         got.cycles = rsp_cycle_count;
         got.status = status_type'(rsp_status);
         got.dest   = rsp_dest_value;
         board.check_result(got);
      end
   end

   // Request side
   initial begin
      int pick;
      int next_shift;
      bit squeezed;
      bit paused;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every transfer form, rejects and abandons
      send_byte(8'hFF);
      send_opcode(lxi_op(RP_HL)); send_byte(8'hFF); send_byte(8'h80);
      send_opcode(lxi_op(RP_SP)); send_byte(8'h00); send_byte(8'hFF);
      send_opcode(lxi_op(RP_BC)); send_byte(8'h12); send_byte(8'h34);
      send_opcode(mvi_op(RC_A)); send_byte(8'hA5);
      send_opcode(mov_op(RC_B, RC_A));
      send_opcode(mov_op(RC_MEM, RC_B));
      send_opcode(mov_op(RC_E, RC_MEM)); send_byte(8'h5A);
      send_opcode(mvi_op(RC_MEM)); send_byte(8'hC3);
      send_opcode(ldst_op(1'b1, 1'b0));
      send_opcode(ldst_op(1'b0, 1'b1)); send_byte(8'h7E);
      send_opcode(OP_HLT);
      send_opcode(OP_RST7);
      send_opcode(OP_NOP);
      send_opcode(mvi_op(RC_C)); send_opcode(mov_op(RC_A, RC_C));
      send_opcode(lxi_op(RP_DE)); send_byte(8'h00); send_opcode(mov_op(RC_L, RC_H));
      settle();

      // random: mostly complete transfers, some broken sequences and noise
      items_sent = 0;
      next_shift = 0;
      squeezed = 1'b0;
      paused = 1'b0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= next_shift) begin
            send_calm = ($urandom_range(0, 2) == 0);
            recv_calm = ($urandom_range(0, 2) == 0);
            next_shift += 80;
         end
         if (!squeezed && items_sent >= 300) begin
            // output held off while requests keep coming
            squeezed = 1'b1;
            hold_off = 1'b1;
            send_calm = 1'b1;
            repeat (40) run_instruction(random_move_op(), 0);
         end
         if (!paused && items_sent >= 600) begin
            paused = 1'b1;
            settle();
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) run_instruction(random_move_op(), 0);
         else if (pick < 80) run_instruction(random_move_op(), 1);
         else if (pick < 87) send_byte(8'($urandom));
         else if (pick < 90) run_instruction(random_move_op(), -1);
         else if (pick < 97) run_instruction(8'($urandom), 0);
         else send_opcode(OP_HLT);
      end
      settle();

      $display("Checked %0d responses: %0d memory reads, %0d writes, %0d completed transfers",
               board.reads + board.writes + board.moves - board.writes
               + board.halts + board.unhandled + board.strays,
               board.reads, board.writes, board.moves);
      $display("Also %0d rejected halts, %0d unhandled opcodes, %0d stray bytes, PC wrapped %0d",
               board.halts, board.unhandled, board.strays, board.pc_wraps);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
